// ----- hdl/spp_pkg.sv -----
`timescale 1ns / 1ps
// shared types, constants and codes of the spectrum packet parser
package spp_pkg;

    // default line capacity of the band store
    localparam int BANDS_DEF   = 16;
    // depth of the command queue between parser and executor
    localparam int QUEUE_DEPTH = 4;

    localparam int SCALE_W = 10;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 10'd100;

    localparam int TMO_W = 18;
    localparam logic [TMO_W-1:0] IDLE_MAX = '1;

    // packet header constants
    localparam logic [15:0] MAGIC_ONE   = (16'd77 << 8) | 16'd222;
    localparam logic [7:0]  MAGIC_TWO   = 8'd66;
    localparam logic [7:0]  PROTO_ID    = 8'd1;
    localparam logic [10:0] VIDEO_SIZE  = 11'd128;
    localparam logic [10:0] HEADER_LEN  = 11'd8;
    localparam logic [10:0] MIN_LEN     = 11'd10;
    localparam logic [1:0]  SIZE_OFFSET = 2'd2;
    localparam logic [7:0]  MIN_LINES   = 8'd2;

    // register index decoded from the address word bit
    localparam logic REG_TIMEOUT_SCALE = 1'b0;

    typedef enum logic [1:0] {
        KIND_BAND   = 2'd0,
        KIND_LEVELS = 2'd1,
        KIND_CLEAR  = 2'd2,
        KIND_REJECT = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        REJ_SIZE     = 3'd0,
        REJ_PROTO    = 3'd1,
        REJ_ZERO_TMO = 3'd2,
        REJ_MAGIC1   = 3'd3,
        REJ_MAGIC2   = 3'd4,
        REJ_LINES    = 3'd5,
        REJ_VIDEO    = 3'd6,
        REJ_UNSUP    = 3'd7
    } t_rej;

    typedef enum logic [2:0] {
        OP_TICK,
        OP_REJECT,
        OP_LEVELS,
        OP_LEVELS_UNSUP,
        OP_CLEAR,
        OP_BANDS
    } t_cmd_op;

    // one classified word handed from parser to executor
    typedef struct packed {
        t_cmd_op     op;
        t_rej        rej;
        logic [7:0]  tmo_byte;
        logic [7:0]  left;
        logic [7:0]  right;
        logic [3:0]  band_start;
        logic [2:0]  band_cnt;
        logic [7:0]  value;
        logic        done;
    } t_cmd;

endpackage

// ----- hdl/spp_in_if.sv -----
`timescale 1ns / 1ps
// input channel: packet bytes and millisecond ticks
interface spp_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [7:0]  data_byte;
    logic        first_of_packet;
    logic [10:0] packet_length;

    modport source (output valid, opcode, data_byte, first_of_packet, packet_length,
                    input ready);
    modport sink   (input valid, opcode, data_byte, first_of_packet, packet_length,
                    output ready);
endinterface

// ----- hdl/spp_out_if.sv -----
`timescale 1ns / 1ps
// output channel: parser results
interface spp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [3:0]  band_index;
    logic [7:0]  band_value;
    logic [7:0]  left_level;
    logic [7:0]  right_level;
    logic [17:0] timeout_ms;
    logic [2:0]  reject_code;
    logic        last;

    modport source (output valid, kind, band_index, band_value, left_level, right_level,
                    timeout_ms, reject_code, last, input ready);
    modport sink   (input valid, kind, band_index, band_value, left_level, right_level,
                    timeout_ms, reject_code, last, output ready);
endinterface

// ----- hdl/spp_front.sv -----
`timescale 1ns / 1ps
// packet parser front: header checks and band byte classification
module spp_front #(
    parameter int BANDS = spp_pkg::BANDS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    spp_in_if.sink        i_pkt,
    input  logic          i_full,
    output logic          o_push,
    output spp_pkg::t_cmd o_cmd
);

    localparam int WP_W = $clog2(BANDS + 1);
    localparam logic [WP_W-1:0] BANDS_WP = WP_W'(BANDS);
    localparam logic [7:0] LINES_FULL = 8'(BANDS);
    localparam logic [7:0] LINES_HALF = 8'(BANDS / 2);
    localparam logic [7:0] LINES_QTR  = 8'(BANDS / 4);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_PAYLOAD
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [2:0]      r_pos, n_pos;
    logic [10:0]     r_len, n_len;
    logic [1:0]      r_mode, n_mode;
    logic [WP_W-1:0] r_wp, n_wp;
    logic [7:0]      r_tmo_byte, n_tmo_byte;
    logic [7:0]      r_magic_lo, n_magic_lo;
    logic [7:0]      r_left, n_left;
    logic [7:0]      r_right, n_right;

    logic            take;
    t_phase          ph;
    logic [2:0]      pos;
    logic [10:0]     len;
    logic [7:0]      b;
    logic [2:0]      rep;
    logic [2:0]      cnt;
    logic [WP_W-1:0] rem;
    logic [WP_W-1:0] wp_next;

    assign i_pkt.ready = !i_full;
    assign take        = i_pkt.valid && i_pkt.ready;
    assign b           = i_pkt.data_byte;

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_len      = r_len;
        n_mode     = r_mode;
        n_wp       = r_wp;
        n_tmo_byte = r_tmo_byte;
        n_magic_lo = r_magic_lo;
        n_left     = r_left;
        n_right    = r_right;
        o_push     = 1'b0;
        o_cmd            = '0;
        o_cmd.tmo_byte   = r_tmo_byte;
        o_cmd.left       = r_left;
        o_cmd.right      = r_right;
        o_cmd.band_start = 4'(r_wp);
        o_cmd.value      = b;
        ph  = r_phase;
        pos = r_pos;
        len = r_len;
        rep = 3'd1;
        cnt = 3'd1;
        rem = BANDS_WP - r_wp;
        wp_next = r_wp;

        if (take) begin
            if (i_pkt.opcode) begin
                o_push   = 1'b1;
                o_cmd.op = spp_pkg::OP_TICK;
            end else begin
                // a first byte abandons any packet in progress
                if (i_pkt.first_of_packet) begin
                    len = i_pkt.packet_length;
                    pos = 3'd0;
                    ph  = PH_HEADER;
                end
                n_len   = len;
                n_phase = ph;
                if (pos != 3'd7) begin
                    n_pos = pos + 3'd1;
                end else begin
                    n_pos = pos;
                end
                unique case (ph)
                    PH_IDLE: begin
                        n_pos = pos;
                    end
                    PH_HEADER: begin
                        case (pos)
                            3'd0: begin
                                if (len >= spp_pkg::VIDEO_SIZE) begin
                                    o_push    = 1'b1;
                                    o_cmd.op  = spp_pkg::OP_REJECT;
                                    o_cmd.rej = spp_pkg::REJ_VIDEO;
                                    n_phase   = PH_IDLE;
                                end else if (b != spp_pkg::PROTO_ID) begin
                                    o_push    = 1'b1;
                                    o_cmd.op  = spp_pkg::OP_REJECT;
                                    o_cmd.rej = spp_pkg::REJ_PROTO;
                                    n_phase   = PH_IDLE;
                                end else if (len < spp_pkg::MIN_LEN ||
                                             len[1:0] != spp_pkg::SIZE_OFFSET) begin
                                    o_push    = 1'b1;
                                    o_cmd.op  = spp_pkg::OP_REJECT;
                                    o_cmd.rej = spp_pkg::REJ_SIZE;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            3'd1: begin
                                n_tmo_byte = b;
                                if (b == 8'd0) begin
                                    o_push    = 1'b1;
                                    o_cmd.op  = spp_pkg::OP_REJECT;
                                    o_cmd.rej = spp_pkg::REJ_ZERO_TMO;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            3'd2: begin
                                n_magic_lo = b;
                            end
                            3'd3: begin
                                if ({b, r_magic_lo} != spp_pkg::MAGIC_ONE) begin
                                    o_push    = 1'b1;
                                    o_cmd.op  = spp_pkg::OP_REJECT;
                                    o_cmd.rej = spp_pkg::REJ_MAGIC1;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            3'd4: begin
                                n_left = b;
                            end
                            3'd5: begin
                                n_right = b;
                            end
                            3'd6: begin
                                if (b != spp_pkg::MAGIC_TWO) begin
                                    o_push    = 1'b1;
                                    o_cmd.op  = spp_pkg::OP_REJECT;
                                    o_cmd.rej = spp_pkg::REJ_MAGIC2;
                                    n_phase   = PH_IDLE;
                                end
                            end
                            default: begin
                                // line count byte
                                o_push  = 1'b1;
                                n_phase = PH_IDLE;
                                if (b < spp_pkg::MIN_LINES || b > LINES_FULL) begin
                                    o_cmd.op  = spp_pkg::OP_REJECT;
                                    o_cmd.rej = spp_pkg::REJ_LINES;
                                end else if (b != LINES_FULL && b != LINES_HALF &&
                                             b != LINES_QTR) begin
                                    o_cmd.op = spp_pkg::OP_LEVELS_UNSUP;
                                end else if ({4'd0, b} + 12'd8 > {1'b0, len}) begin
                                    // short payload undoes the header
                                    o_cmd.op = spp_pkg::OP_CLEAR;
                                end else begin
                                    o_cmd.op = spp_pkg::OP_LEVELS;
                                    n_phase  = PH_PAYLOAD;
                                    n_wp     = '0;
                                    if (b == LINES_FULL) begin
                                        n_mode = 2'd0;
                                    end else if (b == LINES_HALF) begin
                                        n_mode = 2'd1;
                                    end else begin
                                        n_mode = 2'd2;
                                    end
                                end
                            end
                        endcase
                    end
                    PH_PAYLOAD: begin
                        case (r_mode)
                            2'd0:    rep = 3'd1;
                            2'd1:    rep = 3'd2;
                            default: rep = 3'd4;
                        endcase
                        if (rem < WP_W'(rep)) begin
                            cnt = 3'(rem);
                        end else begin
                            cnt = rep;
                        end
                        wp_next          = r_wp + WP_W'(cnt);
                        n_wp             = wp_next;
                        o_push           = 1'b1;
                        o_cmd.op         = spp_pkg::OP_BANDS;
                        o_cmd.band_cnt   = cnt;
                        o_cmd.done       = (wp_next >= BANDS_WP);
                        if (wp_next >= BANDS_WP) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_pos   <= '0;
            r_len   <= '0;
            r_mode  <= '0;
            r_wp    <= '0;
        end else begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_len   <= n_len;
            r_mode  <= n_mode;
            r_wp    <= n_wp;
        end
        r_tmo_byte <= n_tmo_byte;
        r_magic_lo <= n_magic_lo;
        r_left     <= n_left;
        r_right    <= n_right;
    end

`ifndef NO_ASSERTIONS
    // payload phase always has bands left to fill
    a_wp_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_PAYLOAD |-> r_wp < BANDS_WP)
        else $error("write pointer past the band store in payload phase");
`endif

endmodule

// ----- hdl/spp_cmd_fifo.sv -----
`timescale 1ns / 1ps
// short command queue between parser and executor
module spp_cmd_fifo #(
    parameter int DEPTH = spp_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  spp_pkg::t_cmd i_cmd,
    output logic          o_full,
    output logic          o_valid,
    output spp_pkg::t_cmd o_head,
    input  logic          i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    spp_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("command pushed into a full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("command popped from an empty queue");
`endif

endmodule

// ----- hdl/spp_back.sv -----
`timescale 1ns / 1ps
// executor: timeout state, result sequencing and output register
module spp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [spp_pkg::SCALE_W-1:0] i_scale,
    input  logic                        i_valid,
    input  spp_pkg::t_cmd               i_cmd,
    output logic                        o_pop,
    spp_out_if.source                   o_res
);

    typedef struct packed {
        spp_pkg::t_kind             kind;
        logic [3:0]                 band_index;
        logic [7:0]                 band_value;
        logic [7:0]                 left_level;
        logic [7:0]                 right_level;
        logic [spp_pkg::TMO_W-1:0]  timeout_ms;
        spp_pkg::t_rej              reject_code;
        logic                       last;
    } t_result;

    logic [1:0]                r_step, n_step;
    logic                      r_armed, n_armed;
    logic [spp_pkg::TMO_W-1:0] r_limit, n_limit;
    logic [spp_pkg::TMO_W-1:0] r_elapsed, n_elapsed;
    logic                      r_out_valid, n_out_valid;
    t_result                   r_out, n_out;

    logic                      slot_free;
    logic                      go;
    logic                      emit;
    logic                      final_step;
    logic [spp_pkg::TMO_W-1:0] product;
    logic [spp_pkg::TMO_W-1:0] elapsed_inc;
    t_result                   res;

    assign slot_free   = !r_out_valid || o_res.ready;
    assign go          = i_valid && slot_free;
    assign product     = {10'd0, i_cmd.tmo_byte} * {8'd0, i_scale};
    assign elapsed_inc = (r_elapsed == spp_pkg::IDLE_MAX) ? r_elapsed : r_elapsed + 1'b1;

    always_comb begin
        n_step     = r_step;
        n_armed    = r_armed;
        n_limit    = r_limit;
        n_elapsed  = r_elapsed;
        emit       = 1'b0;
        final_step = 1'b1;
        res        = '0;

        if (go) begin
            unique case (i_cmd.op) inside
                spp_pkg::OP_TICK: begin
                    n_elapsed = elapsed_inc;
                    if (r_armed && elapsed_inc >= r_limit) begin
                        emit      = 1'b1;
                        res.kind  = spp_pkg::KIND_CLEAR;
                        n_armed   = 1'b0;
                        n_limit   = '0;
                        n_elapsed = '0;
                    end
                end
                spp_pkg::OP_REJECT: begin
                    emit = 1'b1;
                    if (r_step == 2'd0) begin
                        final_step      = 1'b0;
                        res.kind        = spp_pkg::KIND_REJECT;
                        res.reject_code = i_cmd.rej;
                    end else begin
                        res.kind  = spp_pkg::KIND_CLEAR;
                        n_armed   = 1'b0;
                        n_limit   = '0;
                        n_elapsed = '0;
                    end
                end
                spp_pkg::OP_LEVELS, spp_pkg::OP_LEVELS_UNSUP: begin
                    emit = 1'b1;
                    if (r_step == 2'd0) begin
                        final_step      = (i_cmd.op == spp_pkg::OP_LEVELS);
                        res.kind        = spp_pkg::KIND_LEVELS;
                        res.left_level  = i_cmd.left;
                        res.right_level = i_cmd.right;
                        res.timeout_ms  = product;
                        n_limit         = product;
                        n_armed         = 1'b1;
                    end else begin
                        res.kind        = spp_pkg::KIND_REJECT;
                        res.reject_code = spp_pkg::REJ_UNSUP;
                    end
                end
                spp_pkg::OP_CLEAR: begin
                    emit      = 1'b1;
                    res.kind  = spp_pkg::KIND_CLEAR;
                    n_armed   = 1'b0;
                    n_limit   = '0;
                    n_elapsed = '0;
                end
                spp_pkg::OP_BANDS: begin
                    emit           = 1'b1;
                    res.kind       = spp_pkg::KIND_BAND;
                    res.band_index = i_cmd.band_start + 4'(r_step);
                    res.band_value = i_cmd.value;
                    final_step     = ({1'b0, r_step} == i_cmd.band_cnt - 3'd1);
                    // the last write of an accepted packet restarts the idle count
                    if (final_step && i_cmd.done) begin
                        n_elapsed = '0;
                    end
                end
                default: begin
                    final_step = 1'b1;
                end
            endcase
            res.last = final_step;
            n_step   = final_step ? 2'd0 : r_step + 2'd1;
        end
    end

    assign o_pop = go && final_step;

    always_comb begin
        n_out = r_out;
        if (go && emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_armed     <= 1'b0;
            r_limit     <= '0;
            r_elapsed   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_step      <= n_step;
            r_armed     <= n_armed;
            r_limit     <= n_limit;
            r_elapsed   <= n_elapsed;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.kind        = r_out.kind;
    assign o_res.band_index  = r_out.band_index;
    assign o_res.band_value  = r_out.band_value;
    assign o_res.left_level  = r_out.left_level;
    assign o_res.right_level = r_out.right_level;
    assign o_res.timeout_ms  = r_out.timeout_ms;
    assign o_res.reject_code = r_out.reject_code;
    assign o_res.last        = r_out.last;

`ifndef NO_ASSERTIONS
    // a clear result leaves the timeout disarmed and the idle count at zero
    a_clear_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go && emit && res.kind == spp_pkg::KIND_CLEAR |=> !r_armed && r_elapsed == '0)
        else $error("store clear did not disarm the timeout");
    // the step count only runs while a command is at the queue head
    a_step_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_valid |-> r_step == 2'd0)
        else $error("result step count left over without a command");
`endif

endmodule

// ----- hdl/spectrum_packet_parser.sv -----
`timescale 1ns / 1ps
// top level of the spectrum packet parser
//
// channel  direction  handshake              word
// i_pkt    in         valid/ready            opcode, data_byte, first_of_packet, packet_length
// o_res    out        valid/ready            kind, band_index, band_value, levels,
//                                            timeout_ms, reject_code, last
// apb      in/out     psel/penable/pready    timeout_scale at byte address 0
//
// one input word per cycle is taken while the command queue has room; each word
// becomes at most one queued command in the same cycle
// the executor emits one result per cycle while its output register is free, so a band
// byte in half or quarter mode holds the queue head for up to two or four results and
// input stalls once QUEUE_DEPTH commands wait; the first result of a word reaches o_res
// through the queue write and then the output register; the output register lets input
// flow while a result waits
// synchronous active-low reset, no clearing pass; timeout scale resets to 100
module spectrum_packet_parser #(
    parameter int BANDS       = spp_pkg::BANDS_DEF,
    parameter int QUEUE_DEPTH = spp_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    spp_in_if.sink      i_pkt,
    spp_out_if.source   o_res,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [spp_pkg::SCALE_W-1:0] r_scale;

    logic          push;
    logic          full;
    logic          head_valid;
    logic          pop;
    spp_pkg::t_cmd push_cmd;
    spp_pkg::t_cmd head_cmd;

    // register access: paddr[2] picks the word, no wait states
    assign pready = 1'b1;
    assign prdata = (paddr[2] == spp_pkg::REG_TIMEOUT_SCALE) ?
                    {{(32 - spp_pkg::SCALE_W){1'b0}}, r_scale} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= spp_pkg::SCALE_RESET;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == spp_pkg::REG_TIMEOUT_SCALE) begin
            r_scale <= pwdata[spp_pkg::SCALE_W-1:0];
        end
    end

    // front: header checks, line-count decode and band expansion into commands
    spp_front #(
        .BANDS (BANDS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pkt   (i_pkt),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    // queue decouples parsing from result delivery
    spp_cmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_cmd),
        .i_pop   (pop)
    );

    // back: timeout tracking and one result per cycle to the output register while it is free
    spp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_scale (r_scale),
        .i_valid (head_valid),
        .i_cmd   (head_cmd),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
